@@ sv/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg - shared constants for the 3x3 matrix inverse
// Default widths and the cofactor index tables.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int THR_WIDTH      = 31;
  localparam int N_ELEM         = 9;

  // cofactor i = m[p]*m[q] - m[s]*m[t], entries {p, q, s, t}
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // det = m0*c0 + m1*c3 + m2*c6
  localparam int DET_COF [3] = '{0, 3, 6};

endpackage

@@ sv/mi3_cof.sv @@
// ----------------------------------------------------------------------------
// mi3_cof - adjugate cofactors
// Two stages: eighteen element products, then nine exact differences.
// ----------------------------------------------------------------------------
module mi3_cof #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [ELEM_WIDTH-1:0] m [9],
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [2*ELEM_WIDTH:0] c [9],
  output logic signed [ELEM_WIDTH-1:0] mt [3]
);

  localparam int E  = ELEM_WIDTH;
  localparam int PW = 2 * E;
  localparam int CW = 2 * E + 1;

  logic                v1_r, v2_r;
  logic                rdy1, rdy2;
  logic signed [PW-1:0] pa_r [9];
  logic signed [PW-1:0] pb_r [9];
  logic signed [E-1:0]  m1_r [3];
  logic signed [CW-1:0] c_r  [9];
  logic signed [E-1:0]  m2_r [3];

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign c        = c_r;
  assign mt       = m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      for (int i = 0; i < 9; i++) begin
        pa_r[i] <= PW'(m[mi3_pkg::COF_IDX[i][0]]) * PW'(m[mi3_pkg::COF_IDX[i][1]]);
        pb_r[i] <= PW'(m[mi3_pkg::COF_IDX[i][2]]) * PW'(m[mi3_pkg::COF_IDX[i][3]]);
      end
      for (int i = 0; i < 3; i++) m1_r[i] <= m[i];
    end
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 9; i++) c_r[i] <= CW'(pa_r[i]) - CW'(pb_r[i]);
      m2_r <= m1_r;
    end
  end

endmodule

@@ sv/mi3_det.sv @@
// ----------------------------------------------------------------------------
// mi3_det - determinant, magnitude and singular test
// Five stages: split products, term sums, total, magnitude, compare and pack.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mi3_pkg::THR_WIDTH-1:0]       thr,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [2*ELEM_WIDTH:0]        c_in [9],
  input  logic signed [ELEM_WIDTH-1:0]        mt [3],
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic signed [2*ELEM_WIDTH:0]        c_out [9],
  output logic [3*ELEM_WIDTH+2:0]             dmag,
  output logic                                dneg,
  output logic                                sing,
  output logic [ELEM_WIDTH-1:0]               detv,
  output logic                                dsat
);

  localparam int E   = ELEM_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CW  = 2 * E + 1;
  localparam int PPW = 2 * E + 1;
  localparam int DW  = 3 * E + 3;
  localparam int TW  = DW + 2 * F + mi3_pkg::THR_WIDTH;
  localparam int NS  = 5;

  logic                  v_r [NS];
  logic                  rdy [NS+1];
  logic signed [CW-1:0]  c_r [NS][9];

  logic signed [PPW-1:0] pl_r [3];
  logic signed [PPW-1:0] ph_r [3];
  logic signed [DW-1:0]  t_r  [3];
  logic signed [DW-1:0]  det_r;
  logic [DW-1:0]         mag_r, mag5_r;
  logic                  neg_r, neg5_r;
  logic                  sing_r, dsat_r;
  logic [E-1:0]          detv_r;

  logic [DW-1:0]         dq, lim, mq, sv;
  logic                  over;

  assign rdy[NS] = dn_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign c_out    = c_r[NS-1];
  assign dmag     = mag5_r;
  assign dneg     = neg5_r;
  assign sing     = sing_r;
  assign detv     = detv_r;
  assign dsat     = dsat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NS; s++) if (rdy[s]) v_r[s] <= v_r[s-1];
    end
  end

  // truncate toward zero: magnitude shift, then clip
  always_comb begin
    dq   = mag_r >> (2 * F);
    lim  = neg_r ? (DW'(1) << (E - 1)) : ((DW'(1) << (E - 1)) - DW'(1));
    over = dq > lim;
    mq   = over ? lim : dq;
    sv   = neg_r ? -mq : mq;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      c_r[0] <= c_in;
      for (int i = 0; i < 3; i++) begin
        // cofactor split into unsigned low word and signed high part
        pl_r[i] <= PPW'(mt[i]) *
                   PPW'($signed({1'b0, c_in[mi3_pkg::DET_COF[i]][E-1:0]}));
        ph_r[i] <= PPW'(mt[i]) * PPW'($signed(c_in[mi3_pkg::DET_COF[i]][CW-1:E]));
      end
    end
    if (rdy[1] && v_r[0]) begin
      c_r[1] <= c_r[0];
      for (int i = 0; i < 3; i++) t_r[i] <= (DW'(ph_r[i]) <<< E) + DW'(pl_r[i]);
    end
    if (rdy[2] && v_r[1]) begin
      c_r[2] <= c_r[1];
      det_r  <= t_r[0] + t_r[1] + t_r[2];
    end
    if (rdy[3] && v_r[2]) begin
      c_r[3] <= c_r[2];
      neg_r  <= det_r[DW-1];
      mag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    end
    if (rdy[4] && v_r[3]) begin
      c_r[4] <= c_r[3];
      mag5_r <= mag_r;
      neg5_r <= neg_r;
      sing_r <= TW'(mag_r) <= (TW'(thr) << (2 * F));
      detv_r <= sv[E-1:0];
      dsat_r <= over;
    end
  end

endmodule

@@ sv/mi3_div.sv @@
// ----------------------------------------------------------------------------
// mi3_div - pipelined restoring divider, nine lanes
// One setup stage, then one quotient bit per stage for all nine cofactors.
// ----------------------------------------------------------------------------
module mi3_div #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [2*ELEM_WIDTH:0] c [9],
  input  logic [3*ELEM_WIDTH+2:0]      dmag,
  input  logic                         dneg,
  input  logic                         sing_in,
  input  logic [ELEM_WIDTH-1:0]        detv_in,
  input  logic                         dsat_in,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [ELEM_WIDTH:0]          q [9],
  output logic                         ovf [9],
  output logic                         neg [9],
  output logic                         sing_out,
  output logic [ELEM_WIDTH-1:0]        detv_out,
  output logic                         dsat_out
);

  localparam int E  = ELEM_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 3;
  localparam int QW = E + 1;
  localparam int RW = DW + QW + 2 * F;

  logic          v_r    [QW+1];
  logic          rdy    [QW+2];
  logic [RW-1:0] rem_r  [QW+1][9];
  logic [QW-1:0] q_r    [QW+1][9];
  logic          ovf_r  [QW+1][9];
  logic          neg_r  [QW+1][9];
  logic [DW-1:0] dmag_r [QW+1];
  logic          sing_r [QW+1];
  logic [E-1:0]  detv_r [QW+1];
  logic          dsat_r [QW+1];

  logic [CW-1:0] cmag [9];
  logic [RW-1:0] num0 [9];

  assign rdy[QW+1] = dn_ready;
  for (genvar s = 0; s <= QW; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end
  assign up_ready = rdy[0];
  assign dn_valid = v_r[QW];
  assign q        = q_r[QW];
  assign ovf      = ovf_r[QW];
  assign neg      = neg_r[QW];
  assign sing_out = sing_r[QW];
  assign detv_out = detv_r[QW];
  assign dsat_out = dsat_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QW; s++) v_r[s] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int s = 1; s <= QW; s++) if (rdy[s]) v_r[s] <= v_r[s-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cmag[i] = c[i][CW-1] ? CW'(-c[i]) : CW'(c[i]);
      num0[i] = RW'(cmag[i]) << (2 * F);
    end
  end

  // setup: numerator magnitude, result sign, quotient overflow
  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      for (int i = 0; i < 9; i++) begin
        rem_r[0][i] <= num0[i];
        q_r[0][i]   <= '0;
        neg_r[0][i] <= c[i][CW-1] ^ dneg;
        ovf_r[0][i] <= num0[i] >= (RW'(dmag) << QW);
      end
      dmag_r[0] <= dmag;
      sing_r[0] <= sing_in;
      detv_r[0] <= detv_in;
      dsat_r[0] <= dsat_in;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_bit
    localparam int K = QW - j;
    logic [RW-1:0] d;
    logic          ge [9];
    always_comb begin
      d = RW'(dmag_r[j-1]) << K;
      for (int i = 0; i < 9; i++) ge[i] = rem_r[j-1][i] >= d;
    end
    always_ff @(posedge clk) begin
      if (rdy[j] && v_r[j-1]) begin
        for (int i = 0; i < 9; i++) begin
          rem_r[j][i] <= ge[i] ? rem_r[j-1][i] - d : rem_r[j-1][i];
          q_r[j][i]   <= q_r[j-1][i] | (QW'(ge[i]) << K);
          neg_r[j][i] <= neg_r[j-1][i];
          ovf_r[j][i] <= ovf_r[j-1][i];
        end
        dmag_r[j] <= dmag_r[j-1];
        sing_r[j] <= sing_r[j-1];
        detv_r[j] <= detv_r[j-1];
        dsat_r[j] <= dsat_r[j-1];
      end
    end
  end

endmodule

@@ sv/matrix3_inverse_top.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_top - 3x3 fixed-point matrix inverse by the adjugate rule
// Streaming front end, cofactor, determinant and divider pipelines.
// ----------------------------------------------------------------------------
// One matrix is accepted every cycle and one result leaves every cycle while
// out_tready stays high. The divider resolves one quotient bit per stage
// for all nine cofactors side by side. Every stage holds its item when the
// next one is full, so the input keeps accepting while bubbles remain in
// the pipeline.
// min_abs_det may be written only while no item is in flight.
module matrix3_inverse_top #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mi3_pkg::THR_WIDTH-1:0]           cfg_data,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // a00 a01 a02 a10 a11 a12 a20 a21 a22, zero fill
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // b00 b01 b02 b10 b11 b12 b20 b21 b22 det_value, zero fill
  output logic [((10*ELEM_WIDTH+7)/8)*8-1:0]      out_tdata,
  // singular saturated
  output logic [1:0]                              out_tuser
);

  localparam int E     = ELEM_WIDTH;
  localparam int CW    = 2 * E + 1;
  localparam int DW    = 3 * E + 3;
  localparam int QW    = E + 1;
  localparam int OUT_W = ((10 * E + 7) / 8) * 8;

  logic [mi3_pkg::THR_WIDTH-1:0] thr_r;

  logic signed [E-1:0]  m [9];
  logic signed [CW-1:0] c1 [9], c2 [9];
  logic signed [E-1:0]  mt [3];
  logic                 v1, r1, v2, r2, v3, r3;
  logic [DW-1:0]        dmag;
  logic                 dneg, sing2, dsat2, sing3, dsat3;
  logic [E-1:0]         detv2, detv3;
  logic [QW-1:0]        q [9];
  logic                 ovf [9], neg [9];

  logic [QW-1:0]        lim, mq, sv;
  logic                 over;
  logic [E-1:0]         b [9];
  logic                 sat;
  logic [OUT_W-1:0]     data_nxt, out_tdata_r;
  logic [1:0]           out_tuser_r;
  logic                 out_tvalid_r, rdy_o;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else if (cfg_valid) thr_r <= cfg_data;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = $signed(in_tdata[i*E +: E]);
  end

  mi3_cof #(.ELEM_WIDTH(E)) u_cof (
    .clk(clk), .rst_n(rst_n),
    .up_valid(in_tvalid), .up_ready(in_tready), .m(m),
    .dn_valid(v1), .dn_ready(r1), .c(c1), .mt(mt)
  );

  mi3_det #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .rst_n(rst_n), .thr(thr_r),
    .up_valid(v1), .up_ready(r1), .c_in(c1), .mt(mt),
    .dn_valid(v2), .dn_ready(r2), .c_out(c2), .dmag(dmag), .dneg(dneg),
    .sing(sing2), .detv(detv2), .dsat(dsat2)
  );

  mi3_div #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v2), .up_ready(r2), .c(c2), .dmag(dmag), .dneg(dneg),
    .sing_in(sing2), .detv_in(detv2), .dsat_in(dsat2),
    .dn_valid(v3), .dn_ready(r3), .q(q), .ovf(ovf), .neg(neg),
    .sing_out(sing3), .detv_out(detv3), .dsat_out(dsat3)
  );

  // clip, apply sign, zero out on singular
  always_comb begin
    sat = dsat3;
    lim = '0;
    mq  = '0;
    sv  = '0;
    over = 1'b0;
    for (int i = 0; i < 9; i++) begin
      lim  = neg[i] ? (QW'(1) << (E - 1)) : ((QW'(1) << (E - 1)) - QW'(1));
      over = ovf[i] || (q[i] > lim);
      mq   = over ? lim : q[i];
      sv   = neg[i] ? -mq : mq;
      b[i] = sing3 ? '0 : sv[E-1:0];
      if (!sing3 && over) sat = 1'b1;
    end
    data_nxt = '0;
    for (int i = 0; i < 9; i++) data_nxt[i*E +: E] = b[i];
    data_nxt[9*E +: E] = detv3;
  end

  assign rdy_o = !out_tvalid_r || out_tready;
  assign r3    = rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (rdy_o) out_tvalid_r <= v3;
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v3) begin
      out_tdata_r <= data_nxt;
      out_tuser_r <= {sat, sing3};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ verif/matrix3_inverse_top_tb.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_top_tb - testbench for the 3x3 fixed-point matrix inverse
// Streams matrices with random gaps and stalls across several thresholds,
// predicts each inverse with wide signed arithmetic and checks every transfer.
// ----------------------------------------------------------------------------
class inverse_scoreboard;
  typedef struct {
    logic [31:0] b [9];
    logic [31:0] det;
    logic        singular;
    logic        saturated;
  } inv_result_t;

  inv_result_t pending_q[$];
  logic [30:0] min_abs_det;
  int          err_count;

  function new();
    min_abs_det = '0;
    err_count   = 0;
  endfunction

  // clip a wide signed value to 32 bits
  function logic [31:0] clip32(logic signed [199:0] v, ref logic sat);
    if (v > 200'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -200'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function void note_matrix(logic [287:0] data);
    logic signed [199:0] m [9];
    logic signed [199:0] c [9];
    logic signed [199:0] det, dmag, num, q;
    int                  idx [9][4];
    inv_result_t         r;
    logic                sat;
    idx = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
            '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
            '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
    sat = 1'b0;
    for (int i = 0; i < 9; i++) m[i] = $signed(data[i*32 +: 32]);
    for (int i = 0; i < 9; i++)
      c[i] = m[idx[i][0]] * m[idx[i][1]] - m[idx[i][2]] * m[idx[i][3]];
    det  = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
    dmag = det < 0 ? -det : det;
    r.singular = dmag <= ($signed({169'd0, min_abs_det}) <<< 32);
    // SV division truncates toward zero, as does the block
    r.det = clip32(det / (200'sd1 <<< 32), sat);
    for (int i = 0; i < 9; i++) begin
      if (r.singular) r.b[i] = '0;
      else begin
        num    = c[i] <<< 32;
        q      = num / det;
        r.b[i] = clip32(q, sat);
      end
    end
    r.saturated = sat;
    pending_q.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    err_count++;
  endtask

  task check_result(logic [319:0] data, logic [1:0] user);
    inv_result_t r;
    if (pending_q.size() == 0) begin
      report("unexpected transfer", data[31:0], 32'd0);
      return;
    end
    r = pending_q.pop_front();
    for (int i = 0; i < 9; i++)
      if (data[i*32 +: 32] !== r.b[i]) report($sformatf("b%0d", i), data[i*32 +: 32], r.b[i]);
    if (data[288 +: 32] !== r.det) report("det_value", data[288 +: 32], r.det);
    if (user[0] !== r.singular) report("singular", 32'(user[0]), 32'(r.singular));
    if (user[1] !== r.saturated) report("saturated", 32'(user[1]), 32'(r.saturated));
  endtask
endclass

module matrix3_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 42;
  localparam int MAX_CYCLE = 400000;

  logic         clk, rst_n;
  logic         cfg_valid, cfg_ready;
  logic [30:0]  cfg_data;
  logic         in_tvalid, in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [319:0] out_tdata;
  logic [1:0]   out_tuser;

  inverse_scoreboard inv_sb;
  int  cycle_cnt = 0;
  bit  hold_off;

  matrix3_inverse_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function logic [31:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      2:       return $urandom_range(0, 6) << 16;
      3:       return 32'(-$signed(32'($urandom_range(0, 6) << 16)));
      4:       return 32'($signed(32'($urandom_range(0, 1 << 20))) - (1 << 19));
      5:       return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_matrix(logic [287:0] mat);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = mat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    inv_sb.note_matrix(mat);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (inv_sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [30:0] thr);
    cfg_valid = 1'b1;
    cfg_data  = thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    inv_sb.min_abs_det = thr;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function logic [287:0] diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    return {d2, 96'd0, d1, 96'd0, d0};
  endfunction

  function logic [287:0] rand_matrix();
    logic [287:0] mat;
    for (int i = 0; i < 9; i++) mat[i*32 +: 32] = rand_elem();
    // near-diagonal well-conditioned matrices mostly
    if ($urandom_range(0, 2) != 0)
      for (int i = 0; i < 9; i++)
        mat[i*32 +: 32] = (i % 4 == 0) ? 32'($urandom_range(1, 8) << 16) ^ $urandom_range(0, 65535)
                                       : 32'($signed(32'($urandom_range(0, 1 << 17))) - (1 << 16));
    return mat;
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      out_tready <= stall == 0;
      if (stall != 0) begin
        repeat (stall) @(negedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) inv_sb.check_result(out_tdata, out_tuser);

  initial begin
    logic [30:0] thr_set [6];
    logic [31:0] ext [4];
    inv_sb    = new();
    hold_off  = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: identity, zero, extremes, singular, saturating, tiny det
    ext = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff};
    send_matrix(diag(32'h10000, 32'h10000, 32'h10000));
    send_matrix('0);
    send_matrix({9{32'h80000000}});
    send_matrix({9{32'h7fffffff}});
    send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix(diag(32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_matrix(diag(32'd1, 32'd1, 32'd1));
    send_matrix(diag(32'd1, 32'h10000, 32'h10000));
    send_matrix(diag(32'hffff0000, 32'h20000, 32'h8000));
    send_matrix({32'h30000, 32'h20000, 32'h10000, 32'h60000, 32'h40000,
                 32'h20000, 32'h90000, 32'h60000, 32'h30000});
    for (int k = 0; k < 8; k++) begin
      logic [287:0] mat;
      for (int i = 0; i < 9; i++) mat[i*32 +: 32] = ext[$urandom_range(0, 3)];
      send_matrix(mat);
    end
    wait_drained();

    thr_set = '{31'h7fffffff, 31'h00010000, 31'd1, 31'h00000100, 31'h00400000, 31'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thr_set[ph]);
      for (int n = 0; n < 105; n++) begin
        if (ph == 2 && n == 10) hold_off = 1'b1;
        send_matrix(rand_matrix());
        if (ph == 3 && n == 50) wait_drained();
      end
      wait_drained();
    end

    if (inv_sb.err_count == 0 && inv_sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/mi3_pkg.sv
sv/mi3_cof.sv
sv/mi3_det.sv
sv/mi3_div.sv
sv/matrix3_inverse_top.sv
verif/matrix3_inverse_top_tb.sv
